@@ rtl/r2luv_pkg.sv @@
// ----------------------------------------------------------------------------
// r2luv_pkg
// Shared types, widths and elaboration-time tables for the RGB to L*u*v*
// converter: the gamma linearisation table and the 2^(-2^-i) factor table.
// ----------------------------------------------------------------------------
package r2luv_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned LIN_W         = 31;
  localparam int unsigned LIGHT_W       = 15;
  localparam int unsigned CHROMA_W      = 17;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned POW_STEPS     = 24;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // gamma exponent 2.22 as a fraction
  localparam longint unsigned LIN_POW_NUM = 64'd222;
  localparam longint unsigned LIN_POW_DEN = 64'd100;
  localparam longint unsigned LIN_POW_RND = LIN_POW_DEN / 2;

  typedef logic [LIN_W-1:0] lin_t;

  // one linearised pixel as it travels from the front end to the datapath
  typedef struct packed {
    lin_t lin_r;
    lin_t lin_g;
    lin_t lin_b;
    logic last;
  } lin_pix_t;

  typedef lin_t        lin_tab_t [256];
  typedef logic [29:0] fac_tab_t [POW_STEPS];

  // floor integer square root, bit by bit
  function automatic longint unsigned isqrt(input longint unsigned val);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    v   = val;
    res = 64'd0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // t^2.22 in Q30 via 2^(p*log2 t); same rounding as the datapath
  function automatic longint unsigned frac_pow(input longint unsigned t);
    longint unsigned m;
    longint unsigned fr;
    longint unsigned g;
    longint unsigned y;
    longint unsigned k;
    longint unsigned f;
    longint unsigned r;
    longint unsigned s;
    longint unsigned e;
    if (t == 64'd0) return 64'd0;
    m  = (t > Q30_ONE) ? Q30_ONE : t;
    e  = 64'd0;
    fr = 64'd0;
    while (m < Q30_ONE) begin
      m = m << 1;
      e = e + 64'd1;
    end
    for (int i = 1; i <= 24; i++) begin
      m = (m * m + (64'd1 << 29)) >> 30;
      if (m >= (64'd1 << 31)) begin
        m  = m >> 1;
        fr = fr | (64'd1 << (24 - i));
      end
    end
    g = (e << 24) - fr;
    y = (g * LIN_POW_NUM + LIN_POW_RND) / LIN_POW_DEN;
    k = y >> 24;
    f = y & ((64'd1 << 24) - 64'd1);
    r = Q30_ONE;
    s = isqrt(64'd1 << 59);
    for (int i = 1; i <= 24; i++) begin
      if (((f >> (24 - i)) & 64'd1) != 64'd0) r = (r * s + (64'd1 << 29)) >> 30;
      s = isqrt(s << 30);
    end
    if (k >= 64'd40) return 64'd0;
    if (k > 64'd0) r = (r + (64'd1 << (k - 64'd1))) >> k;
    return r;
  endfunction

  function automatic longint unsigned linearise(input longint unsigned c);
    longint unsigned t;
    if (c <= 64'd20) return (((c * 64'd8715) << 30) + 64'd5000000) / 64'd10000000;
    t = (((c * 64'd1000 + 64'd25245) << 30) + 64'd140122) / 64'd280245;
    return frac_pow(t);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) tab[c] = lin_t'(linearise(64'(c)));
    return tab;
  endfunction

  // factor i (from 0) is 2^(-2^-(i+1)) in Q30
  function automatic fac_tab_t build_fac_tab();
    fac_tab_t        tab;
    longint unsigned s;
    s = isqrt(64'd1 << 59);
    for (int i = 0; i < POW_STEPS; i++) begin
      tab[i] = 30'(s);
      s      = isqrt(s << 30);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB  = build_lin_tab();
  localparam fac_tab_t POW2_FAC = build_fac_tab();

endpackage

@@ rtl/r2luv_front.sv @@
// ----------------------------------------------------------------------------
// r2luv_front
// Input stage: takes one RGB request, linearises each channel by table and
// holds the result until the queue takes it.
// ----------------------------------------------------------------------------
module r2luv_front import r2luv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       last_i,
  output logic       pix_valid_o,
  input  logic       pix_ready_i,
  output lin_pix_t   pix_o
);

  logic     valid_q;
  lin_pix_t pix_q;
  lin_pix_t pix_d;
  logic     accept;
  logic     push;

  assign push      = valid_q & pix_ready_i;
  assign s_ready_o = ~valid_q | pix_ready_i;
  assign accept    = s_valid_i & s_ready_o;

  always_comb begin
    pix_d.lin_r = LIN_TAB[red_i];
    pix_d.lin_g = LIN_TAB[green_i];
    pix_d.lin_b = LIN_TAB[blue_i];
    pix_d.last  = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept | (valid_q & ~push);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_d;
    end
  end

  assign pix_valid_o = valid_q;
  assign pix_o       = pix_q;

endmodule

@@ rtl/r2luv_fifo.sv @@
// ----------------------------------------------------------------------------
// r2luv_fifo
// Short queue of linearised pixels between the front end and the datapath.
// ----------------------------------------------------------------------------
module r2luv_fifo import r2luv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lin_pix_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lin_pix_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  lin_pix_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign in_ready_o  = cnt_q != CNT_W'(FIFO_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign do_push     = in_valid_i & in_ready_o;
  assign do_pop      = out_ready_i & out_valid_o;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push & ~do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop & ~do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

@@ rtl/r2luv_back.sv @@
// ----------------------------------------------------------------------------
// r2luv_back
// Datapath: matrix, XYZ scaling, u'/v' division, cube root and chroma.
// One long pipeline that advances as a whole whenever the result can move.
// ----------------------------------------------------------------------------
module r2luv_back import r2luv_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pix_valid_i,
  output logic                pix_ready_o,
  input  lin_pix_t            pix_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [LIGHT_W-1:0]  lightness_o,
  output logic [CHROMA_W-1:0] u_chroma_o,
  output logic [CHROMA_W-1:0] v_chroma_o,
  output logic                last_o
);

  // quotient bits of the u'/v' restoring divider
  localparam int unsigned QB = 31;

  // stage map
  localparam int unsigned ST_SUM  = 1;
  localparam int unsigned ST_XRCP = ST_SUM + 1;
  localparam int unsigned ST_XFIX = ST_XRCP + 1;
  localparam int unsigned ST_PREP = ST_XFIX + 1;
  localparam int unsigned ST_NORM = ST_PREP + 1;
  localparam int unsigned ST_UV   = ST_NORM + 1;
  localparam int unsigned ST_LOG  = ST_UV + QB;
  localparam int unsigned ST_POW  = ST_LOG + 1;
  localparam int unsigned ST_CUBE = ST_POW + POW_STEPS;
  localparam int unsigned N_ST    = ST_CUBE + 5;

  localparam logic [19:0] MAT [3][3] = '{
    '{20'd412453, 20'd357580, 20'd180423},
    '{20'd212671, 20'd715160, 20'd72169},
    '{20'd19334,  20'd119193, 20'd950227}
  };

  localparam longint unsigned WDEN   = 64'd982 + 64'd15000 + 64'd3549;
  localparam longint unsigned UW_L   = ((64'd3928 << 28) + WDEN / 2) / WDEN;
  localparam longint unsigned VW_L   = ((64'd9000 << 28) + WDEN / 2) / WDEN;
  localparam longint unsigned UBLK_L = ((64'd4 << 28) + 64'd9) / 64'd19;
  localparam longint unsigned VBLK_L = ((64'd9 << 28) + 64'd9) / 64'd19;
  localparam longint unsigned YTHR_L = (64'd8856 << 30) / 64'd1000000;
  localparam longint unsigned XRCP_L = (64'd1 << 46) / 64'd15625;

  localparam logic [30:0] UW      = 31'(UW_L);
  localparam logic [30:0] VW      = 31'(VW_L);
  localparam logic [30:0] U_BLK   = 31'(UBLK_L);
  localparam logic [30:0] V_BLK   = 31'(VBLK_L);
  localparam logic [30:0] Y_THR   = 31'(YTHR_L);
  localparam logic [32:0] XYZ_RCP = 33'(XRCP_L);
  localparam logic [44:0] XYZ_D5  = 45'd15625;
  localparam logic [22:0] L_MAX   = 23'd6553600;
  localparam int unsigned SH      = 44 - OUT_FRAC_BITS;
  localparam logic [57:0] C_RND   = 58'd1 << (SH - 1);

  typedef struct packed {
    logic [2:0][44:0] nq;
    logic [2:0][30:0] q0;
  } xrcp_t;

  typedef struct packed {
    logic [61:0] nu;
    logic [61:0] nv;
    logic [35:0] dd;
    logic        blk;
    logic        cube;
    logic [4:0]  e;
    logic [44:0] pl;
    logic [30:0] y;
  } prep_t;

  typedef struct packed {
    logic [61:0] ru;
    logic [61:0] rv;
    logic [30:0] qu;
    logic [30:0] qv;
    logic [35:0] dd;
    logic        blk;
    logic        cube;
    logic [4:0]  e;
    logic [31:0] m;
    logic [23:0] fr;
    logic [26:0] llin;
  } uv_t;

  typedef struct packed {
    logic [30:0] r;
    logic [23:0] f;
    logic [4:0]  k;
    logic        su;
    logic        sv;
    logic [30:0] mu;
    logic [30:0] mv;
    logic        cube;
    logic [26:0] llin;
  } pow_t;

  typedef struct packed {
    logic [30:0] c;
    logic        su;
    logic        sv;
    logic [30:0] mu;
    logic [30:0] mv;
    logic        cube;
    logic [26:0] llin;
  } cube_t;

  typedef struct packed {
    logic [22:0] l16;
    logic        su;
    logic        sv;
    logic [30:0] mu;
    logic [30:0] mv;
  } l16_t;

  typedef struct packed {
    logic [26:0]        l13;
    logic [LIGHT_W-1:0] light;
    logic               su;
    logic               sv;
    logic [30:0]        mu;
    logic [30:0]        mv;
  } l13_t;

  typedef struct packed {
    logic [57:0]        pu;
    logic [57:0]        pv;
    logic               su;
    logic               sv;
    logic [LIGHT_W-1:0] light;
  } prod_t;

  typedef struct packed {
    logic [LIGHT_W-1:0]  light;
    logic [CHROMA_W-1:0] u;
    logic [CHROMA_W-1:0] v;
  } out_t;

  logic [N_ST-1:0]  vld_q;
  logic [N_ST-1:0]  lst_q;
  logic             en;

  logic [2:0][2:0][50:0] prod_q, prod_d;
  logic [2:0][50:0]      sum_q, sum_d;
  xrcp_t                 xrcp_q, xrcp_d;
  logic [2:0][30:0]      xyz_q, xyz_d;
  prep_t                 prep_q, prep_d;
  uv_t                   norm_q, norm_d;
  uv_t                   uv_q [QB];
  uv_t                   uv_d [QB];
  pow_t                  log_q, log_d;
  pow_t                  pow_q [POW_STEPS];
  pow_t                  pow_d [POW_STEPS];
  cube_t                 cube_q, cube_d;
  l16_t                  l16_q, l16_d;
  l13_t                  l13_q, l13_d;
  prod_t                 mul_q, mul_d;
  out_t                  out_q, out_d;

  // whole pipeline moves unless a finished result is held
  assign en          = ~vld_q[N_ST-1] | res_ready_i;
  assign pix_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_ST-2:0], pix_valid_i};
    end
  end

  // matrix products
  always_comb begin
    lin_t chan [3];
    chan[0] = pix_i.lin_r;
    chan[1] = pix_i.lin_g;
    chan[2] = pix_i.lin_b;
    for (int rw = 0; rw < 3; rw++) begin
      for (int cl = 0; cl < 3; cl++) begin
        prod_d[rw][cl] = 51'(MAT[rw][cl]) * 51'(chan[cl]);
      end
    end
  end

  // row sums with rounding offset for the /10^6
  always_comb begin
    for (int rw = 0; rw < 3; rw++) begin
      sum_d[rw] = prod_q[rw][0] + prod_q[rw][1] + prod_q[rw][2] + 51'd500000;
    end
  end

  // X, Y, Z = sum / 10^6: drop 2^6, then estimate / 15625 by reciprocal
  always_comb begin
    logic [44:0] nq;
    logic [63:0] hp;
    for (int rw = 0; rw < 3; rw++) begin
      nq = sum_q[rw][50:6];
      hp = 64'(nq[44:14]) * 64'(XYZ_RCP);
      xrcp_d.nq[rw] = nq;
      xrcp_d.q0[rw] = hp[62:32];
    end
  end

  // estimate is low by at most two; fix by compare against the remainder
  always_comb begin
    logic [44:0] resid;
    for (int rw = 0; rw < 3; rw++) begin
      resid     = xrcp_q.nq[rw] - 45'(xrcp_q.q0[rw]) * XYZ_D5;
      xyz_d[rw] = xrcp_q.q0[rw] + 31'(resid >= XYZ_D5) + 31'(resid >= (XYZ_D5 << 1));
    end
  end

  // denominator, dividends, branch flags, normalize count, linear L* product
  always_comb begin
    logic [30:0] cx;
    logic [30:0] cy;
    logic [30:0] cz;
    logic [35:0] half;
    cx = xyz_q[0];
    cy = xyz_q[1];
    cz = xyz_q[2];
    prep_d.dd   = 36'(cx) + (36'(cy) << 4) - 36'(cy) + (36'(cz) << 1) + 36'(cz);
    half        = prep_d.dd >> 1;
    prep_d.nu   = (62'(cx) << 30) + 62'(half);
    prep_d.nv   = (62'(cy) << 31) + (62'(cy) << 28) + 62'(half);
    prep_d.blk  = prep_d.dd == '0;
    prep_d.cube = cy > Y_THR;
    prep_d.e    = '0;
    for (int b = 0; b < 31; b++) begin
      if (cy[b]) prep_d.e = 5'(30 - b);
    end
    prep_d.pl = 45'(cy) * 45'd9033;
    prep_d.y  = cy;
  end

  // mantissa into [1,2) in Q30; linear L* = (P + 5*2^14) / (10*2^14)
  always_comb begin
    logic [45:0] xs;
    logic [61:0] q5;
    xs = 46'(prep_q.pl) + 46'd81920;
    q5 = 62'(xs[45:15]) * 62'd858993460;
    norm_d.ru   = prep_q.nu;
    norm_d.rv   = prep_q.nv;
    norm_d.qu   = '0;
    norm_d.qv   = '0;
    norm_d.dd   = prep_q.dd;
    norm_d.blk  = prep_q.blk;
    norm_d.cube = prep_q.cube;
    norm_d.e    = prep_q.e;
    norm_d.m    = 32'(prep_q.y) << prep_q.e;
    norm_d.fr   = '0;
    norm_d.llin = q5[58:32];
  end

  // u', v' division bit by bit; log2 squaring in the first stages
  always_comb begin
    uv_t         src;
    logic [65:0] dsh;
    logic [63:0] sq;
    logic [33:0] sr;
    for (int j = 0; j < QB; j++) begin
      src = (j == 0) ? norm_q : uv_q[j-1];
      dsh = 66'(src.dd) << (QB - 1 - j);
      if (66'(src.ru) >= dsh) begin
        src.ru              = src.ru - dsh[61:0];
        src.qu[QB - 1 - j]  = 1'b1;
      end
      if (66'(src.rv) >= dsh) begin
        src.rv              = src.rv - dsh[61:0];
        src.qv[QB - 1 - j]  = 1'b1;
      end
      if (j < POW_STEPS) begin
        sq = 64'(src.m) * 64'(src.m);
        sr = 34'((sq + 64'd536870912) >> 30);
        if (sr[31]) begin
          src.m                         = sr[32:1];
          src.fr[POW_STEPS - 1 - j]     = 1'b1;
        end else begin
          src.m = sr[31:0];
        end
      end
      uv_d[j] = src;
    end
  end

  // log2(Y)/3 and chroma differences against the white point
  always_comb begin
    logic [30:0] up;
    logic [30:0] vp;
    logic [28:0] g1;
    logic [60:0] yq;
    up = uv_q[QB-1].blk ? U_BLK : uv_q[QB-1].qu;
    vp = uv_q[QB-1].blk ? V_BLK : uv_q[QB-1].qv;
    g1 = (29'(uv_q[QB-1].e) << 24) - 29'(uv_q[QB-1].fr) + 29'd1;
    yq = 61'(g1) * 61'(32'hAAAAAAAB);
    log_d.r    = 31'(Q30_ONE);
    log_d.f    = yq[56:33];
    log_d.k    = 5'(yq[60:57]);
    log_d.su   = up < UW;
    log_d.sv   = vp < VW;
    log_d.mu   = log_d.su ? UW - up : up - UW;
    log_d.mv   = log_d.sv ? VW - vp : vp - VW;
    log_d.cube = uv_q[QB-1].cube;
    log_d.llin = uv_q[QB-1].llin;
  end

  // 2^-frac as a product of table factors, one per stage
  always_comb begin
    pow_t        src;
    logic [60:0] pr;
    for (int j = 0; j < POW_STEPS; j++) begin
      src = (j == 0) ? log_q : pow_q[j-1];
      pr  = 61'(src.r) * 61'(POW2_FAC[j]) + 61'd536870912;
      if (src.f[POW_STEPS - 1 - j]) begin
        src.r = pr[60:30];
      end
      pow_d[j] = src;
    end
  end

  // integer part of the exponent: rounded right shift
  always_comb begin
    logic [31:0] acc;
    pow_t        src;
    src = pow_q[POW_STEPS-1];
    acc = 32'(src.r) + ((src.k == '0) ? 32'd0 : (32'd1 << (src.k - 5'd1)));
    cube_d.c    = 31'(acc >> src.k);
    cube_d.su   = src.su;
    cube_d.sv   = src.sv;
    cube_d.mu   = src.mu;
    cube_d.mv   = src.mv;
    cube_d.cube = src.cube;
    cube_d.llin = src.llin;
  end

  // L* in Q16, from the cube root or the linear segment, clamped to 100
  always_comb begin
    logic [37:0] p116;
    logic [37:0] dl;
    logic [26:0] lc;
    logic [26:0] sel;
    p116 = 38'(cube_q.c) * 38'd116;
    dl   = (p116 > (38'd16 << 30)) ? p116 - (38'd16 << 30) : '0;
    lc   = 27'((dl + 38'd8192) >> 14);
    sel  = cube_q.cube ? lc : cube_q.llin;
    l16_d.l16 = (sel > 27'(L_MAX)) ? L_MAX : sel[22:0];
    l16_d.su  = cube_q.su;
    l16_d.sv  = cube_q.sv;
    l16_d.mu  = cube_q.mu;
    l16_d.mv  = cube_q.mv;
  end

  always_comb begin
    logic [23:0] lr;
    lr = 24'(l16_q.l16) + (24'd1 << (15 - OUT_FRAC_BITS));
    l13_d.l13   = (27'(l16_q.l16) << 3) + (27'(l16_q.l16) << 2) + 27'(l16_q.l16);
    l13_d.light = LIGHT_W'(lr >> (16 - OUT_FRAC_BITS));
    l13_d.su    = l16_q.su;
    l13_d.sv    = l16_q.sv;
    l13_d.mu    = l16_q.mu;
    l13_d.mv    = l16_q.mv;
  end

  always_comb begin
    mul_d.pu    = 58'(l13_q.l13) * 58'(l13_q.mu);
    mul_d.pv    = 58'(l13_q.l13) * 58'(l13_q.mv);
    mul_d.su    = l13_q.su;
    mul_d.sv    = l13_q.sv;
    mul_d.light = l13_q.light;
  end

  // round half away from zero, then saturate
  function automatic logic [CHROMA_W-1:0] chroma_sat(input logic [57:0] mag,
                                                     input logic        neg);
    logic [57:0] rm;
    logic [16:0] cap;
    rm = (mag + C_RND) >> SH;
    if (neg) begin
      cap = (rm > 58'd65536) ? 17'h10000 : rm[16:0];
      return CHROMA_W'(-cap);
    end else begin
      cap = (rm > 58'd65535) ? 17'h0ffff : rm[16:0];
      return CHROMA_W'(cap);
    end
  endfunction

  always_comb begin
    out_d.light = mul_q.light;
    out_d.u     = chroma_sat(mul_q.pu, mul_q.su);
    out_d.v     = chroma_sat(mul_q.pv, mul_q.sv);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lst_q  <= {lst_q[N_ST-2:0], pix_i.last};
      prod_q <= prod_d;
      sum_q  <= sum_d;
      xrcp_q <= xrcp_d;
      xyz_q  <= xyz_d;
      for (int j = 0; j < QB; j++) begin
        uv_q[j] <= uv_d[j];
      end
      prep_q <= prep_d;
      norm_q <= norm_d;
      log_q  <= log_d;
      for (int j = 0; j < POW_STEPS; j++) begin
        pow_q[j] <= pow_d[j];
      end
      cube_q <= cube_d;
      l16_q  <= l16_d;
      l13_q  <= l13_d;
      mul_q  <= mul_d;
      out_q  <= out_d;
    end
  end

  assign res_valid_o = vld_q[N_ST-1];
  assign last_o      = lst_q[N_ST-1];
  assign lightness_o = out_q.light;
  assign u_chroma_o  = out_q.u;
  assign v_chroma_o  = out_q.v;

endmodule

@@ rtl/rgb_to_luv_convert.sv @@
// ----------------------------------------------------------------------------
// rgb_to_luv_convert
// 8-bit RGB pixel stream in, CIE L*u*v* fixed-point pixel stream out.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: red, green, blue; tlast: last
//  m_axis    out  tvalid/tready           tdata: L*, u*, v*; tlast: last
//
// One pixel per clock sustained while results are taken. Path from request
// accept to result accept: front table register, queue, then a 67-stage
// datapath set by the 31-step restoring divider for u'/v' (log2 squarings
// ride alongside) and the 24 factor-product stages of the cube root; XYZ
// scaling takes two. Reset clears valid flags, queue pointers and count
// only; there is no clearing pass. A held result freezes the datapath; the
// 4-entry queue and the front register keep taking requests until they fill.
// ----------------------------------------------------------------------------
module rgb_to_luv_convert import r2luv_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // lightness[14:0], u_chroma[31:15],
                                      // v_chroma[48:32], zero[55:49]
  output logic        m_axis_tlast    // last_pixel_out
);

  logic                front_valid;
  logic                front_ready;
  lin_pix_t            front_pix;
  logic                queue_valid;
  logic                queue_ready;
  lin_pix_t            queue_pix;
  logic [LIGHT_W-1:0]  lightness;
  logic [CHROMA_W-1:0] u_chroma;
  logic [CHROMA_W-1:0] v_chroma;

  // front: linearise each channel by table lookup
  r2luv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .last_i      (s_axis_tlast),
    .pix_valid_o (front_valid),
    .pix_ready_i (front_ready),
    .pix_o       (front_pix)
  );

  // decouples front from datapath stalls
  r2luv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_pix),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_data_o  (queue_pix)
  );

  // back: XYZ, u'/v', L* and chroma; last stage is the output register
  r2luv_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (queue_valid),
    .pix_ready_o (queue_ready),
    .pix_i       (queue_pix),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .lightness_o (lightness),
    .u_chroma_o  (u_chroma),
    .v_chroma_o  (v_chroma),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, v_chroma, u_chroma, lightness};

endmodule
